@@ rtl/hlt_pkg.sv @@
// Shared constants and types of the header/length/tail frame receiver.
`default_nettype none

package hlt_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int POS_W        = 9;
    localparam int PADDR_W      = 3;

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET   = 8'h55;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_DROP   = 2'd2,
        ST_READ   = 2'd3
    } t_status;

    typedef enum logic {
        ACT_RECEIVE = 1'b0,
        ACT_READ    = 1'b1
    } t_action;

    typedef enum logic {
        REG_HEADER = 1'b0,
        REG_TAIL   = 1'b1
    } t_reg_index;

endpackage

`default_nettype wire

@@ rtl/hlt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/header_length_tail_frame_receiver_unit.sv @@
// Top level of the header/length/tail frame receiver.
//
// Takes one word per cycle while o_in_stall is low, each a received byte or a read
// of the frame buffer, and returns exactly one result word for each; the stage
// register waits on the registered read port of the frame buffer RAM. Input
// and output are parted by a stage register and an output register, so a new
// word is taken while a result waits. No clearing pass after reset: buffer
// entries never written read back as undefined data.
`default_nettype none

module header_length_tail_frame_receiver_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_action,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic [7:0]                  i_read_index,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [1:0]                  o_status,
    output logic      [7:0]                  o_frame_id,
    output logic      [8:0]                  o_frame_length,
    output logic      [7:0]                  o_read_data,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hlt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    import hlt_pkg::*;

    // configuration registers
    logic [7:0] r_header;
    logic [7:0] r_tail;
    logic       cfg_we;
    t_reg_index cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_tail   <= TAIL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_HEADER: r_header <= pwdata[7:0];
                REG_TAIL:   r_tail   <= pwdata[7:0];
                default:    r_header <= r_header;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_HEADER: prdata[7:0] = r_header;
            REG_TAIL:   prdata[7:0] = r_tail;
            default:    prdata      = '0;
        endcase
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic in_acc;
    logic s1_move;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign s1_move     = r_s1_valid && out_free;
    assign o_out_valid = r_out_valid;

    // receiver state
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_len;
    logic [7:0]       r_id;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_len;
    logic [7:0]       n_id;
    t_status          rx_status;
    logic [POS_W-1:0] len_plus2;
    logic [9:0]       byte_plus3;
    logic             is_read;

    assign is_read    = (t_action'(i_action) == ACT_READ);
    assign len_plus2  = {1'b0, r_len} + POS_W'(2);
    assign byte_plus3 = {2'b00, i_data_byte} + 10'd3;

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_id      = r_id;
        rx_status = ST_NONE;
        priority if (r_pos == POS_W'(0)) begin
            if (i_data_byte == r_header) begin
                n_pos = POS_W'(1);
            end
        end else if (r_pos == POS_W'(1)) begin
            n_id  = i_data_byte;
            n_pos = POS_W'(2);
        end else if (r_pos == POS_W'(2)) begin
            n_len = i_data_byte;
            if (byte_plus3 > 10'(BUFFER_DEPTH)) begin
                rx_status = ST_DROP;
                n_pos     = '0;
            end else begin
                n_pos = POS_W'(3);
            end
        end else if (r_pos < len_plus2) begin
            n_pos = r_pos + POS_W'(1);
        end else if (r_pos == len_plus2 && i_data_byte == r_tail) begin
            rx_status = ST_ACCEPT;
            n_pos     = '0;
        end else begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_id  <= '0;
        end else if (in_acc && !is_read) begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_id  <= n_id;
        end
    end

    // frame buffer
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              rd_in_range;

    assign ram_we      = in_acc && !is_read && (r_pos < POS_W'(BUFFER_DEPTH));
    assign rd_in_range = {1'b0, i_read_index} < POS_W'(BUFFER_DEPTH);
    assign ram_re      = in_acc && is_read;
    assign ram_raddr   = ADDR_W'(i_read_index);

    hlt_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // stage register: wait for the buffer read
    t_status    r_s1_status;
    logic [7:0] r_s1_id;
    logic [8:0] r_s1_len;
    logic       r_s1_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd_ok <= rd_in_range;
            if (is_read) begin
                r_s1_status <= ST_READ;
                r_s1_id     <= '0;
                r_s1_len    <= '0;
            end else begin
                r_s1_status <= rx_status;
                r_s1_id     <= (rx_status == ST_ACCEPT) ? r_id : 8'd0;
                r_s1_len    <= (rx_status == ST_ACCEPT) ? 9'(len_plus2 + POS_W'(1)) : 9'd0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_status       <= r_s1_status;
            o_frame_id     <= r_s1_id;
            o_frame_length <= r_s1_len;
            o_read_data    <= (r_s1_status == ST_READ && r_s1_rd_ok) ? ram_rdata : 8'd0;
        end
    end

endmodule

`default_nettype wire
